// ===== design/tld_pkg.sv =====
// shared constants, types and helpers for the tty line discipline
package tld_pkg;

    // receive character queue
    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CHAR_W      = 7;

    // job queue between front and back
    localparam int JOBQ_DEPTH  = 2;
    localparam int JPTR_W      = $clog2(JOBQ_DEPTH);
    localparam int JCNT_W      = $clog2(JOBQ_DEPTH + 1);

    // input commands
    localparam logic [1:0] CMD_RX    = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_TX     = 3'd1;
    localparam logic [2:0] KIND_RDATA  = 3'd2;
    localparam logic [2:0] KIND_REMPTY = 3'd3;
    localparam logic [2:0] KIND_WSTOP  = 3'd4;
    localparam logic [2:0] KIND_WDISC  = 3'd5;

    // classified job operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_INTR    = 4'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 4'd2;
    localparam logic [OP_W-1:0] OP_STOP    = 4'd3;
    localparam logic [OP_W-1:0] OP_START   = 4'd4;
    localparam logic [OP_W-1:0] OP_ERASE   = 4'd5;
    localparam logic [OP_W-1:0] OP_CHAR    = 4'd6;
    localparam logic [OP_W-1:0] OP_READ    = 4'd7;
    localparam logic [OP_W-1:0] OP_WRITE   = 4'd8;

    // character codes
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SI    = 8'h0f;
    localparam logic [7:0] CH_DC1   = 8'h11;
    localparam logic [7:0] CH_DC3   = 8'h13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MASK = 8'h7f;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      data;
    } t_job;

    // circular index helpers
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] p);
        return (p == '0) ? IDX_W'(QUEUE_DEPTH - 1) : p - IDX_W'(1);
    endfunction

endpackage

// ===== design/tty_line_discipline_top.sv =====
// top level of the tty line discipline
//
// Input channel (i_in_valid / o_in_ready) carries one command per
// transaction: 0 a received byte, 1 read one queued character, 2 write one
// output byte. Output channel (o_out_valid / i_out_ready) carries one
// result per transaction; o_last marks the final result of a command.
// A command produces one to three results.
// The front end classifies each command and holds it in a two-entry job
// queue; the back end takes one job at a time, issues the character ram
// read as it takes the job, updates the queue state in its decide state,
// then emits one result per cycle while the receiver accepts them.
// Reset empties the character queue and clears the stop and discard
// flags. When the receiver stalls, the result is held in the output
// register, the back end waits, and once the job queue fills o_in_ready
// drops.
module tty_line_discipline_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_interrupt_request,
    output logic       o_line_ready,
    output logic       o_last
);

    logic          job_valid;
    tld_pkg::t_job job;
    logic          job_pop;

    tld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    tld_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_job_valid         (job_valid),
        .i_job               (job),
        .o_job_pop           (job_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_out_byte          (o_out_byte),
        .o_interrupt_request (o_interrupt_request),
        .o_line_ready        (o_line_ready),
        .o_last              (o_last)
    );

endmodule

// ===== design/tld_ram.sv =====
// generic single-write, single-read ram with registered read data
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tld_front.sv =====
// front end: accepts input transactions, classifies them and queues jobs
module tld_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_data_byte,
    output logic              o_job_valid,
    output tld_pkg::t_job     o_job,
    input  logic              i_job_pop
);

    tld_pkg::t_job                  r_q [tld_pkg::JOBQ_DEPTH];
    logic [tld_pkg::JPTR_W-1:0]     r_wp, n_wp;
    logic [tld_pkg::JPTR_W-1:0]     r_rp, n_rp;
    logic [tld_pkg::JCNT_W-1:0]     r_cnt, n_cnt;
    tld_pkg::t_job                  cls_job;
    logic [6:0]                     c;
    logic                           push;
    logic                           pop;

    // classify the incoming transaction
    always_comb begin
        c = i_data_byte[6:0];
        cls_job.op   = tld_pkg::OP_NONE;
        cls_job.data = 8'h00;
        unique case (i_command)
            tld_pkg::CMD_RX: begin
                if ({1'b0, c} == tld_pkg::CH_ETX) begin
                    cls_job.op = tld_pkg::OP_INTR;
                end else if ({1'b0, c} == tld_pkg::CH_SI) begin
                    cls_job.op = tld_pkg::OP_DISCARD;
                end else if ({1'b0, c} == tld_pkg::CH_DC3) begin
                    cls_job.op = tld_pkg::OP_STOP;
                end else if ({1'b0, c} == tld_pkg::CH_DC1) begin
                    cls_job.op = tld_pkg::OP_START;
                end else if ({1'b0, c} == tld_pkg::CH_BS) begin
                    cls_job.op = tld_pkg::OP_ERASE;
                end else if ({1'b0, c} == tld_pkg::CH_CR) begin
                    cls_job.op   = tld_pkg::OP_CHAR;
                    cls_job.data = tld_pkg::CH_LF;
                end else begin
                    cls_job.op   = tld_pkg::OP_CHAR;
                    cls_job.data = i_data_byte & tld_pkg::CHAR_MASK;
                end
            end
            tld_pkg::CMD_READ: begin
                cls_job.op = tld_pkg::OP_READ;
            end
            tld_pkg::CMD_WRITE: begin
                cls_job.op   = tld_pkg::OP_WRITE;
                cls_job.data = i_data_byte;
            end
            default: begin
                cls_job.op = tld_pkg::OP_NONE;
            end
        endcase
    end

    assign o_in_ready  = (r_cnt != tld_pkg::JCNT_W'(tld_pkg::JOBQ_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_job_pop && o_job_valid;

    // job queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == tld_pkg::JPTR_W'(tld_pkg::JOBQ_DEPTH - 1)) ?
                   '0 : r_wp + tld_pkg::JPTR_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == tld_pkg::JPTR_W'(tld_pkg::JOBQ_DEPTH - 1)) ?
                   '0 : r_rp + tld_pkg::JPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + tld_pkg::JCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - tld_pkg::JCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls_job;
        end
    end

endmodule

// ===== design/tld_back.sv =====
// back end: executes jobs against the character queue and emits results
module tld_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  tld_pkg::t_job     i_job,
    output logic              o_job_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_out_byte,
    output logic              o_interrupt_request,
    output logic              o_line_ready,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0]                    r_state, n_state;
    tld_pkg::t_job                 r_job;
    logic [tld_pkg::IDX_W-1:0]     r_head, n_head;
    logic [tld_pkg::IDX_W-1:0]     r_tail, n_tail;
    logic [tld_pkg::CNT_W-1:0]     r_fill, n_fill;
    logic                          r_stop, n_stop;
    logic                          r_disc, n_disc;

    // result plan for the current job
    logic [2:0]                    r_pkind [3];
    logic [7:0]                    r_pbyte [3];
    logic [1:0]                    r_num;
    logic [1:0]                    r_idx;
    logic                          r_irq;
    logic                          r_rdy;
    logic [2:0]                    p_kind [3];
    logic [7:0]                    p_byte [3];
    logic [1:0]                    p_num;
    logic                          p_irq;
    logic                          p_rdy;

    // output register
    logic                          r_ov;
    logic [2:0]                    r_okind;
    logic [7:0]                    r_obyte;
    logic                          r_oirq;
    logic                          r_ordy;
    logic                          r_olast;

    // memory ports
    logic                          mem_we;
    logic                          mem_re;
    logic [tld_pkg::IDX_W-1:0]     mem_raddr;
    logic [tld_pkg::CHAR_W-1:0]    mem_rdata;

    logic                          emit_ok;
    logic                          emit_last;
    logic                          pop;
    logic                          full;
    logic [6:0]                    c;

    tld_ram #(
        .WIDTH (tld_pkg::CHAR_W),
        .DEPTH (tld_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (r_job.data[6:0]),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencing and job pop
    assign emit_ok   = (r_state == S_EMIT) && (!r_ov || i_out_ready);
    assign emit_last = emit_ok && (r_idx == r_num - 2'd1);
    assign pop       = i_job_valid && ((r_state == S_IDLE) || emit_last);
    assign o_job_pop = pop;

    // read address is issued as the job is taken
    assign mem_re    = pop;
    assign mem_raddr = (i_job.op == tld_pkg::OP_ERASE) ? tld_pkg::prev_idx(r_tail) : r_head;

    assign full = (r_fill == tld_pkg::CNT_W'(tld_pkg::QUEUE_DEPTH));
    assign c    = r_job.data[6:0];

    // job execution: state update and result plan
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_stop = r_stop;
        n_disc = r_disc;
        mem_we = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p_kind[i] = tld_pkg::KIND_NONE;
            p_byte[i] = 8'h00;
        end
        p_num = 2'd1;
        p_irq = 1'b0;
        p_rdy = 1'b0;
        unique case (r_job.op)
            tld_pkg::OP_INTR: begin
                p_irq = 1'b1;
            end
            tld_pkg::OP_DISCARD: begin
                n_disc = !r_disc;
            end
            tld_pkg::OP_STOP: begin
                n_stop = 1'b1;
            end
            tld_pkg::OP_START: begin
                n_stop = 1'b0;
            end
            tld_pkg::OP_ERASE: begin
                if (r_fill != '0 && {1'b0, mem_rdata} != tld_pkg::CH_LF) begin
                    n_tail    = tld_pkg::prev_idx(r_tail);
                    n_fill    = r_fill - tld_pkg::CNT_W'(1);
                    p_num     = 2'd3;
                    p_kind[0] = tld_pkg::KIND_TX;
                    p_kind[1] = tld_pkg::KIND_TX;
                    p_kind[2] = tld_pkg::KIND_TX;
                    p_byte[0] = tld_pkg::CH_BS;
                    p_byte[1] = tld_pkg::CH_SPACE;
                    p_byte[2] = tld_pkg::CH_BS;
                end
            end
            tld_pkg::OP_CHAR: begin
                if (!full) begin
                    mem_we = 1'b1;
                    n_tail = tld_pkg::next_idx(r_tail);
                    n_fill = r_fill + tld_pkg::CNT_W'(1);
                end
                p_rdy = ({1'b0, c} == tld_pkg::CH_LF) || ({1'b0, c} == tld_pkg::CH_EOT);
                if ({1'b0, c} == tld_pkg::CH_LF) begin
                    p_num     = 2'd2;
                    p_kind[0] = tld_pkg::KIND_TX;
                    p_byte[0] = tld_pkg::CH_CR;
                    p_kind[1] = tld_pkg::KIND_TX;
                    p_byte[1] = full ? tld_pkg::CH_BEL : tld_pkg::CH_LF;
                end else begin
                    p_kind[0] = tld_pkg::KIND_TX;
                    p_byte[0] = full ? tld_pkg::CH_BEL : {1'b0, c};
                end
            end
            tld_pkg::OP_READ: begin
                if (r_fill != '0) begin
                    n_head    = tld_pkg::next_idx(r_head);
                    n_fill    = r_fill - tld_pkg::CNT_W'(1);
                    p_kind[0] = tld_pkg::KIND_RDATA;
                    p_byte[0] = {1'b0, mem_rdata};
                end else begin
                    p_kind[0] = tld_pkg::KIND_REMPTY;
                end
            end
            tld_pkg::OP_WRITE: begin
                if (r_stop) begin
                    p_kind[0] = tld_pkg::KIND_WSTOP;
                end else if (r_disc) begin
                    p_kind[0] = tld_pkg::KIND_WDISC;
                end else if (r_job.data == tld_pkg::CH_LF) begin
                    p_num     = 2'd2;
                    p_kind[0] = tld_pkg::KIND_TX;
                    p_byte[0] = tld_pkg::CH_CR;
                    p_kind[1] = tld_pkg::KIND_TX;
                    p_byte[1] = tld_pkg::CH_LF;
                end else begin
                    p_kind[0] = tld_pkg::KIND_TX;
                    p_byte[0] = r_job.data;
                end
            end
            default: begin
                p_kind[0] = tld_pkg::KIND_NONE;
            end
        endcase
        if (r_state != S_DECIDE) begin
            n_head = r_head;
            n_tail = r_tail;
            n_fill = r_fill;
            n_stop = r_stop;
            n_disc = r_disc;
            mem_we = 1'b0;
        end
    end

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = pop ? S_DECIDE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_stop  <= 1'b0;
            r_disc  <= 1'b0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_stop  <= n_stop;
            r_disc  <= n_disc;
            if (emit_ok) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_DECIDE) begin
                r_idx <= '0;
            end else if (emit_ok) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // job and plan payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
        end
        if (r_state == S_DECIDE) begin
            r_pkind <= p_kind;
            r_pbyte <= p_byte;
            r_num   <= p_num;
            r_irq   <= p_irq;
            r_rdy   <= p_rdy;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit_ok) begin
            r_okind <= r_pkind[r_idx];
            r_obyte <= r_pbyte[r_idx];
            r_oirq  <= r_irq;
            r_ordy  <= r_rdy;
            r_olast <= (r_idx == r_num - 2'd1);
        end
    end

    assign o_out_valid         = r_ov;
    assign o_kind              = r_okind;
    assign o_out_byte          = r_obyte;
    assign o_interrupt_request = r_oirq;
    assign o_line_ready        = r_ordy;
    assign o_last              = r_olast;

endmodule

// ===== design/tld_checker.sv =====
// port-level checks for the tty line discipline, bound to the top level
module tld_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] o_kind,
    input  logic [7:0] o_out_byte,
    input  logic       o_interrupt_request,
    input  logic       o_line_ready,
    input  logic       o_last
);

    // a stalled result transaction stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_kind) && $stable(o_out_byte)
            && $stable(o_interrupt_request) && $stable(o_line_ready) && $stable(o_last))
        else $error("result payload changed while stalled");

    // kinds without data carry a zero byte
    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == tld_pkg::KIND_NONE || o_kind == tld_pkg::KIND_REMPTY
            || o_kind == tld_pkg::KIND_WSTOP || o_kind == tld_pkg::KIND_WDISC)
        |-> o_out_byte == 8'h00)
        else $error("nonzero byte on a result without data");

    // queued characters are 7 bit
    a_read_7bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == tld_pkg::KIND_RDATA |-> !o_out_byte[7])
        else $error("read character wider than 7 bits");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind tty_line_discipline_top tld_checker u_tld_checker (.*);
